@@ src/inf_pkg.sv @@
// Package for the impulse noise mean filter: frame geometry, widths, shared types.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package inf_pkg;
	localparam int WIDTH = 188;
	localparam int HEIGHT = 120;
	localparam int PIX_W = 8;
	localparam int POS_W = 10;
	localparam int COL_W = $clog2(WIDTH);
	localparam int ROW_W = $clog2(HEIGHT);
	localparam int CFG_IDX_W = 2;
	localparam int SUM_W = 12;
	localparam int RECIP_W = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
	localparam logic [PIX_W-1:0] BRIGHT_RESET = 8'd100;
	localparam logic [PIX_W-1:0] DIFF_RESET = 8'd10;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_idx_t;
	typedef logic [ROW_W-1:0] row_idx_t;
	// One window column, index 0 is the oldest row.
	typedef pix_t [2:0] col_t;
	// Line buffer entry: upper byte is two rows back, lower byte is one row back.
	typedef logic [2*PIX_W-1:0] lb_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHT = 2'd0,
		REG_DIFF   = 2'd1
	} reg_idx_t;
endpackage
`default_nettype wire

@@ src/inf_line_buf.sv @@
// Line buffer memory holding the previous two rows packed per column.
// Depends on inf_pkg for the row length and word type.
`default_nettype none
module inf_line_buf (
	input  wire                    clk,
	input  wire                    rd_en,
	input  wire inf_pkg::col_idx_t rd_addr,
	input  wire                    wr_en,
	input  wire inf_pkg::col_idx_t wr_addr,
	input  wire inf_pkg::lb_word_t wr_data,
	output inf_pkg::lb_word_t      rd_data_q
);
	inf_pkg::lb_word_t mem [inf_pkg::WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

@@ src/inf_cell.sv @@
// One column cell of the 3x3 window; cells are chained and shift one column per word.
// Depends on inf_pkg for the column type.
`default_nettype none
module inf_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 shift_en,
	input  wire inf_pkg::col_t  col_in,
	output inf_pkg::col_t       col_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end
endmodule
`default_nettype wire

@@ src/impulse_noise_mean_filter_top.sv @@
// Each word costs one line buffer read, one write and one window shift.
// Throughput: one word per clock while the pipeline is not stalled by result_stall.
// Reset: position and window cleared, thresholds return to 100 and 10.
// Line buffer is not cleared; unwritten words only reach rows 0 and 1, which give no result.
// Top level: line buffer, chain of three window cells, noise test and mean pipeline.
// Depends on inf_pkg, inf_line_buf and inf_cell.
`default_nettype none
module impulse_noise_mean_filter_top (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [inf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [inf_pkg::PIX_W-1:0]      cfg_data,
	input  wire                           pixel_valid,
	output logic                          pixel_stall,
	input  wire [inf_pkg::PIX_W-1:0]      pixel,
	input  wire                           frame_start,
	output logic                          result_valid,
	input  wire                           result_stall,
	output logic [inf_pkg::PIX_W-1:0]     filtered,
	output logic [inf_pkg::POS_W-1:0]     out_row,
	output logic [inf_pkg::POS_W-1:0]     out_col,
	output logic                          replaced,
	output logic                          frame_last
);
	function automatic logic differs(input inf_pkg::pix_t a, input inf_pkg::pix_t b,
			input inf_pkg::pix_t thr);
		inf_pkg::pix_t d;
		d = (a >= b) ? (a - b) : (b - a);
		return d > thr;
	endfunction

	inf_pkg::pix_t bright_q, diff_q;
	inf_pkg::row_idx_t row_q;
	inf_pkg::col_idx_t col_q;

	logic v_s1, v_s2, v_s3;
	inf_pkg::pix_t px_s1;
	inf_pkg::row_idx_t r_s1, r_s2, r_s3;
	inf_pkg::col_idx_t c_s1, c_s2, c_s3;
	logic byp_s1;
	inf_pkg::lb_word_t byp_data_s1;
	logic noise_s3;
	logic [inf_pkg::SUM_W-1:0] sum_s3;
	inf_pkg::pix_t ctr_s3;

	logic accept, out_free, s3_ready, s2_ready, s1_ready, s1_leave, s2_leave, s3_leave;
	inf_pkg::row_idx_t r_in;
	inf_pkg::col_idx_t c_in;
	inf_pkg::lb_word_t rd_data, lb_eff, wr_data;
	inf_pkg::col_t new_col, col0, col1, col2;
	logic noise;
	logic [inf_pkg::SUM_W-1:0] sum;
	logic [inf_pkg::SUM_W+inf_pkg::RECIP_W-1:0] prod;

	assign out_free = !result_valid || !result_stall;
	assign s3_ready = !v_s3 || out_free;
	assign s2_ready = !v_s2 || s3_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign s1_leave = v_s1 && s2_ready;
	assign s2_leave = v_s2 && s3_ready;
	assign s3_leave = v_s3 && out_free;
	assign pixel_stall = !s1_ready;
	assign accept = pixel_valid && s1_ready;

	assign r_in = frame_start ? '0 : row_q;
	assign c_in = frame_start ? '0 : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= inf_pkg::BRIGHT_RESET;
			diff_q <= inf_pkg::DIFF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				inf_pkg::REG_BRIGHT: bright_q <= cfg_data;
				inf_pkg::REG_DIFF:   diff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (c_in == inf_pkg::COL_W'(inf_pkg::WIDTH - 1)) begin
				col_q <= '0;
				row_q <= (r_in == inf_pkg::ROW_W'(inf_pkg::HEIGHT - 1)) ? '0 :
					r_in + inf_pkg::ROW_W'(1);
			end else begin
				col_q <= c_in + inf_pkg::COL_W'(1);
				row_q <= r_in;
			end
		end
	end

	inf_line_buf u_line_buf (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (c_in),
		.wr_en     (s1_leave),
		.wr_addr   (c_s1),
		.wr_data   (wr_data),
		.rd_data_q (rd_data)
	);

	assign lb_eff = byp_s1 ? byp_data_s1 : rd_data;
	assign wr_data = {lb_eff[inf_pkg::PIX_W-1:0], px_s1};
	assign new_col[0] = lb_eff[2*inf_pkg::PIX_W-1:inf_pkg::PIX_W];
	assign new_col[1] = lb_eff[inf_pkg::PIX_W-1:0];
	assign new_col[2] = px_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_leave) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= pixel;
			r_s1 <= r_in;
			c_s1 <= c_in;
			byp_s1 <= s1_leave && (c_s1 == c_in);
			byp_data_s1 <= wr_data;
		end
	end

	inf_cell u_cell2 (.clk(clk), .arst_n(arst_n), .shift_en(s1_leave),
		.col_in(new_col), .col_q(col2));
	inf_cell u_cell1 (.clk(clk), .arst_n(arst_n), .shift_en(s1_leave),
		.col_in(col2), .col_q(col1));
	inf_cell u_cell0 (.clk(clk), .arst_n(arst_n), .shift_en(s1_leave),
		.col_in(col1), .col_q(col0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_leave) begin
			v_s2 <= (r_s1 >= inf_pkg::ROW_W'(2)) && (c_s1 >= inf_pkg::COL_W'(2));
		end else if (s2_leave) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave) begin
			r_s2 <= r_s1;
			c_s2 <= c_s1;
		end
	end

	always_comb begin
		noise = (col1[1] >= bright_q)
			&& differs(col1[1], col0[0], diff_q) && differs(col1[1], col2[0], diff_q)
			&& differs(col1[1], col0[2], diff_q) && differs(col1[1], col2[2], diff_q);
		sum = inf_pkg::SUM_W'(col0[0]) + inf_pkg::SUM_W'(col0[1]) + inf_pkg::SUM_W'(col0[2])
			+ inf_pkg::SUM_W'(col1[0]) + inf_pkg::SUM_W'(col1[1]) + inf_pkg::SUM_W'(col1[2])
			+ inf_pkg::SUM_W'(col2[0]) + inf_pkg::SUM_W'(col2[1]) + inf_pkg::SUM_W'(col2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s2_leave) begin
			v_s3 <= 1'b1;
		end else if (s3_leave) begin
			v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_leave) begin
			noise_s3 <= noise;
			sum_s3 <= sum;
			ctr_s3 <= col1[1];
			r_s3 <= r_s2;
			c_s3 <= c_s2;
		end
	end

	assign prod = (inf_pkg::SUM_W+inf_pkg::RECIP_W)'(sum_s3) *
		(inf_pkg::SUM_W+inf_pkg::RECIP_W)'(inf_pkg::RECIP_9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s3_leave) begin
			result_valid <= 1'b1;
		end else if (out_free) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_leave) begin
			filtered <= noise_s3 ?
				prod[inf_pkg::RECIP_SHIFT+inf_pkg::PIX_W-1:inf_pkg::RECIP_SHIFT] : ctr_s3;
			out_row <= inf_pkg::POS_W'(r_s3 - inf_pkg::ROW_W'(1));
			out_col <= inf_pkg::POS_W'(c_s3 - inf_pkg::COL_W'(1));
			replaced <= noise_s3;
			frame_last <= (r_s3 == inf_pkg::ROW_W'(inf_pkg::HEIGHT - 1))
				&& (c_s3 == inf_pkg::COL_W'(inf_pkg::WIDTH - 1));
		end
	end
endmodule
`default_nettype wire
